// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also holds while reset is applied.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- sv/mbdl_pkg.sv -----
// Package with sizes, byte codes, register indexes and types of the MIDI delay line.
package mbdl_pkg;

    localparam int DEPTH = 1024;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Commands carried in the input tuser bit.
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Register indexes (paddr[3:2]).
    localparam logic [1:0] REG_DELAY_EN   = 2'd0;
    localparam logic [1:0] REG_DELAY_TIME = 2'd1;
    localparam logic [1:0] REG_PC_TO_CC   = 2'd2;

    // MIDI byte codes.
    localparam logic [7:0] PC_LOW    = 8'hC0;
    localparam logic [7:0] PC_HIGH   = 8'hCF;
    localparam logic [7:0] CHAN_MASK = 8'h0F;
    localparam logic [7:0] CC_STATUS = 8'hB0;
    localparam logic [7:0] CC_NUMBER = 8'h00;
    localparam logic [7:0] CC_VALUE  = 8'h7F;

    typedef struct packed {
        logic [31:0] stamp;
        logic [7:0]  data;
    } entry_t;

    typedef struct packed {
        logic          en;
        logic [AW-1:0] addr;
        entry_t        data;
    } wr_req_t;

    typedef struct packed {
        logic          en;
        logic [AW-1:0] addr;
    } rd_req_t;

    // Ring pointer increment that wraps at DEPTH.
    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

endpackage

// ----- sv/mbdl_store.sv -----
// Entry memory of the delay line: byte and time stamp, one write and one registered read a cycle.
module mbdl_store (
    input  logic              aclk,
    input  mbdl_pkg::wr_req_t wr,
    input  mbdl_pkg::rd_req_t rd,
    output mbdl_pkg::entry_t  rdata
);

    mbdl_pkg::entry_t mem [mbdl_pkg::DEPTH];
    mbdl_pkg::entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            rdata_reg <= mem[rd.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/midi_byte_delay_line.sv -----
// Top level of the timestamped MIDI byte delay line.
//
//  Channel  Direction  Handshake          Payload
//  s_       in         s_tvalid/s_tready  s_tuser = cmd, s_tdata = rx_byte, tx_ready
//  m_       out        m_tvalid/m_tready  m_tuser = dropped, m_tdata = tx_byte
//  APB      in/out     psel/penable       delay on/off, delay time, program change conversion
//
// A stored byte is one memory write, a converted program change four (one memory
// write per cycle). A tick advances the time and reads the oldest entry when ready.
// An item register takes the next item while one is at work; a release or a drop waits
// while the output register holds an item not yet taken, and then the input stalls.
// Reset is synchronous and active low; the memory gets no clearing pass, since only
// entries counted by the fill count are ever read.
module midi_byte_delay_line (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input item channel.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // [7:0] rx_byte, [8] tx_ready, rest zero
    input  logic                          s_tuser,   // [0] cmd
    // Result channel.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] tx_byte
    output logic                          m_tuser,   // [0] dropped
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mbdl_pkg::ADDR_W-1:0]   paddr,
    input  logic [mbdl_pkg::DATA_W-1:0]   pwdata,
    output logic [mbdl_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CC_NUM,
        ST_CC_VAL,
        ST_PC,
        ST_EVAL
    } state_t;

    // Configuration registers.
    logic        delay_en_reg;
    logic [31:0] delay_time_reg;
    logic        pc_to_cc_reg;

    // Engine state.
    state_t                    state_reg,  state_next;
    logic [mbdl_pkg::AW-1:0]   wp_reg,     wp_next;
    logic [mbdl_pkg::AW-1:0]   rp_reg,     rp_next;
    logic [mbdl_pkg::CW-1:0]   fill_reg,   fill_next;
    logic [31:0]               time_reg,   time_next;
    logic [7:0]                pend_reg,   pend_next;

    // Item register in front of the engine.
    logic       item_valid_reg, item_valid_next;
    logic       item_cmd_reg,   item_cmd_next;
    logic [7:0] item_byte_reg,  item_byte_next;
    logic       item_rdy_reg,   item_rdy_next;

    // Output register.
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_byte_reg,  m_byte_next;
    logic       m_drop_reg,  m_drop_next;

    mbdl_pkg::wr_req_t wr;
    mbdl_pkg::rd_req_t rd;
    mbdl_pkg::entry_t  rdata;

    logic        cfg_write;
    logic        convert;
    logic        fits;
    logic        slot_free;
    logic        head_ready;
    logic        take;
    logic        due;
    logic [31:0] age;

    mbdl_store u_store (
        .aclk  (aclk),
        .wr    (wr),
        .rd    (rd),
        .rdata (rdata)
    );

    // Configuration port: writes complete in the access phase, pready is always high.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_en_reg   <= 1'b0;
            delay_time_reg <= '0;
            pc_to_cc_reg   <= 1'b0;
        end else if (cfg_write) begin
            case (paddr[3:2])
                mbdl_pkg::REG_DELAY_EN:   delay_en_reg   <= pwdata[0];
                mbdl_pkg::REG_DELAY_TIME: delay_time_reg <= pwdata;
                mbdl_pkg::REG_PC_TO_CC:   pc_to_cc_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            mbdl_pkg::REG_DELAY_EN:   prdata = {31'b0, delay_en_reg};
            mbdl_pkg::REG_DELAY_TIME: prdata = delay_time_reg;
            mbdl_pkg::REG_PC_TO_CC:   prdata = {31'b0, pc_to_cc_reg};
            default:                  prdata = '0;
        endcase
    end

    // A program change is converted only when the feature is on. The group of one or
    // four bytes is stored only if it fits completely into the free entries.
    assign convert = pc_to_cc_reg && (item_byte_reg >= mbdl_pkg::PC_LOW) &&
                     (item_byte_reg <= mbdl_pkg::PC_HIGH);
    assign fits    = convert ? (fill_reg <= mbdl_pkg::CW'(mbdl_pkg::DEPTH - 4))
                             : (fill_reg <= mbdl_pkg::CW'(mbdl_pkg::DEPTH - 1));

    assign slot_free  = !m_valid_reg || m_tready;
    assign head_ready = (fill_reg != '0) && item_rdy_reg;

    // The engine takes the waiting item in idle unless it must report a drop and the
    // output register is still occupied.
    assign take = item_valid_reg && (state_reg == ST_IDLE) &&
                  (item_cmd_reg == mbdl_pkg::CMD_TICK || fits || slot_free);

    assign s_tready = !item_valid_reg || take;

    // Age is a modular difference; time_reg already holds the advanced time here.
    assign age = time_reg - rdata.stamp;
    assign due = !delay_en_reg || (age >= delay_time_reg);

    always_comb begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        fill_next       = fill_reg;
        time_next       = time_reg;
        pend_next       = pend_reg;
        item_valid_next = item_valid_reg;
        item_cmd_next   = item_cmd_reg;
        item_byte_next  = item_byte_reg;
        item_rdy_next   = item_rdy_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_byte_next     = m_byte_reg;
        m_drop_next     = m_drop_reg;

        wr.en         = 1'b0;
        wr.addr       = wp_reg;
        wr.data.stamp = time_reg;
        wr.data.data  = '0;
        rd.en         = 1'b0;
        rd.addr       = rp_reg;

        if (s_tvalid && s_tready) begin
            item_valid_next = 1'b1;
            item_cmd_next   = s_tuser;
            item_byte_next  = s_tdata[7:0];
            item_rdy_next   = s_tdata[8];
        end else if (take) begin
            item_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    if (item_cmd_reg == mbdl_pkg::CMD_TICK) begin
                        time_next = time_reg + 32'd1;
                        if (head_ready) begin
                            rd.en      = 1'b1;
                            state_next = ST_EVAL;
                        end
                    end else if (!fits) begin
                        m_valid_next = 1'b1;
                        m_byte_next  = item_byte_reg;
                        m_drop_next  = 1'b1;
                    end else begin
                        wr.en     = 1'b1;
                        wp_next   = mbdl_pkg::ptr_inc(wp_reg);
                        fill_next = fill_reg + mbdl_pkg::CW'(1);
                        if (convert) begin
                            wr.data.data = mbdl_pkg::CC_STATUS |
                                           (item_byte_reg & mbdl_pkg::CHAN_MASK);
                            pend_next    = item_byte_reg;
                            state_next   = ST_CC_NUM;
                        end else begin
                            wr.data.data = item_byte_reg;
                        end
                    end
                end
            end
            ST_CC_NUM: begin
                wr.en        = 1'b1;
                wr.data.data = mbdl_pkg::CC_NUMBER;
                wp_next      = mbdl_pkg::ptr_inc(wp_reg);
                fill_next    = fill_reg + mbdl_pkg::CW'(1);
                state_next   = ST_CC_VAL;
            end
            ST_CC_VAL: begin
                wr.en        = 1'b1;
                wr.data.data = mbdl_pkg::CC_VALUE;
                wp_next      = mbdl_pkg::ptr_inc(wp_reg);
                fill_next    = fill_reg + mbdl_pkg::CW'(1);
                state_next   = ST_PC;
            end
            ST_PC: begin
                wr.en        = 1'b1;
                wr.data.data = pend_reg;
                wp_next      = mbdl_pkg::ptr_inc(wp_reg);
                fill_next    = fill_reg + mbdl_pkg::CW'(1);
                state_next   = ST_IDLE;
            end
            ST_EVAL: begin
                // The head entry read in the previous cycle is held in the read register
                // until the output register has room.
                if (!due) begin
                    state_next = ST_IDLE;
                end else if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = rdata.data;
                    m_drop_next  = 1'b0;
                    rp_next      = mbdl_pkg::ptr_inc(rp_reg);
                    fill_next    = fill_reg - mbdl_pkg::CW'(1);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            wp_reg         <= '0;
            rp_reg         <= '0;
            fill_reg       <= '0;
            time_reg       <= '0;
            pend_reg       <= '0;
            item_valid_reg <= 1'b0;
            item_cmd_reg   <= 1'b0;
            item_byte_reg  <= '0;
            item_rdy_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_byte_reg     <= '0;
            m_drop_reg     <= 1'b0;
        end else begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            rp_reg         <= rp_next;
            fill_reg       <= fill_next;
            time_reg       <= time_next;
            pend_reg       <= pend_next;
            item_valid_reg <= item_valid_next;
            item_cmd_reg   <= item_cmd_next;
            item_byte_reg  <= item_byte_next;
            item_rdy_reg   <= item_rdy_next;
            m_valid_reg    <= m_valid_next;
            m_byte_reg     <= m_byte_next;
            m_drop_reg     <= m_drop_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = m_drop_reg;

endmodule

// ----- sv/mbdl_checker.sv -----
// Port checker for the MIDI delay line, bound to the top level.
`include "assert_macros.svh"

module mbdl_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [7:0]                  m_tdata,
    input logic                        m_tuser,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [mbdl_pkg::ADDR_W-1:0] paddr,
    input logic [mbdl_pkg::DATA_W-1:0] pwdata,
    input logic [mbdl_pkg::DATA_W-1:0] prdata,
    input logic                        pready
);

    logic                        out_stall;
    logic [8:0]                  out_word;
    logic                        delay_time_wr;
    logic                        delay_time_rd;
    logic                        readback_ok;
    logic [mbdl_pkg::DATA_W-1:0] pwdata_reg;

    assign out_stall     = m_tvalid && !m_tready;
    assign out_word      = {m_tuser, m_tdata};
    assign delay_time_wr = psel && penable && pwrite && pready &&
                           (paddr[3:2] == mbdl_pkg::REG_DELAY_TIME);
    assign delay_time_rd = psel && !pwrite && (paddr[3:2] == mbdl_pkg::REG_DELAY_TIME);
    assign readback_ok   = !delay_time_rd || (prdata == pwdata_reg);

    // Write data of the previous cycle, for the read-back check.
    always_ff @(posedge aclk) begin
        pwdata_reg <= pwdata;
    end

    `ASSERT_CLK(a_out_valid_holds, out_stall |=> m_tvalid, "result withdrawn while stalled")
    `ASSERT_CLK(a_out_payload_holds, out_stall |=> $stable(out_word), "result changed while stalled")
    `ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_tvalid, "result valid right after reset")
    `ASSERT_CLK(a_delay_readback, delay_time_wr |=> readback_ok, "delay time reads back wrong")

endmodule

bind midi_byte_delay_line mbdl_checker u_mbdl_checker (.*);
